// ===== rtl/core/ymrx_pkg.sv =====
// Package for the YMODEM receive controller.
// Holds the protocol byte codes, block sizes, state and result types.
// Used by ymodem_receive_controller and ymrx_checker.
package ymrx_pkg;

  localparam int unsigned ShortBlock  = 128;
  localparam int unsigned LongBlock   = 1024;
  localparam int unsigned HeaderBytes = 3;

  localparam int unsigned IdxW      = 11;
  localparam int unsigned TdataOutW = 80;

  localparam logic [7:0] ByteSoh   = 8'h01;
  localparam logic [7:0] ByteStx   = 8'h02;
  localparam logic [7:0] ByteEot   = 8'h04;
  localparam logic [7:0] ReplyAck  = 8'h06;
  localparam logic [7:0] ReplyNak  = 8'h15;
  localparam logic [7:0] ReplyC    = 8'h43;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharSpace = 8'h20;

  localparam logic [IdxW-1:0] IdxMax = {IdxW{1'b1}};

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_ERASE = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    PS_HEADER = 4'b0001,
    PS_DATA   = 4'b0010,
    PS_EOT2   = 4'b0100,
    PS_CLOSE  = 4'b1000
  } proto_state_e;

  typedef enum logic [1:0] {
    PT_OTHER = 2'd0,
    PT_SOH   = 2'd1,
    PT_STX   = 2'd2,
    PT_EOT   = 2'd3
  } packet_type_e;

  typedef enum logic [2:0] {
    HP_NAME = 3'b001,
    HP_SIZE = 3'b010,
    HP_DONE = 3'b100
  } header_phase_e;

  localparam logic [2:0] RegBaseAddr = 3'd0;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] address;
    logic [7:0]  value;
    logic [31:0] erase_length;
    logic        session_ok;
    logic        last;
  } res_t;

endpackage

// ===== rtl/core/ymodem_receive_controller.sv =====
// YMODEM receive controller: turns received packet bytes into flash writes,
// erase requests, protocol replies and session-end notices.
// Each input byte is registered, then its results are registered for output.
// Throughput: one input byte per cycle when the output is not stalled; a byte
// with k results (at most three) stalls the input until k-1 have been taken.
// Reset clears protocol state, counters, base address and all valid flags.
module ymodem_receive_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,   // packet_end
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [ymrx_pkg::TdataOutW-1:0] m_axis_tdata, // [31:0] out_address,
                                      // [39:32] out_value, [71:40] erase_length,
                                      // [72] session_ok, [79:73] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
  output logic        m_axis_tlast    // last
);

  localparam int unsigned IdxW = ymrx_pkg::IdxW;

  logic [31:0] base_q;

  logic              in_valid_q;
  logic [7:0]        byte_q;
  logic              end_q;

  ymrx_pkg::proto_state_e  ps_q, ps_d;
  ymrx_pkg::packet_type_e  pt_q, pt_d;
  ymrx_pkg::header_phase_e hp_q, hp_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic [31:0]             acc_q, acc_d;
  logic [31:0]             fsize_q, fsize_d;
  logic [31:0]             offset_q, offset_d;

  ymrx_pkg::res_t res_q [3];
  ymrx_pkg::res_t res_d [3];
  logic [1:0]     rem_q;
  logic [1:0]     n_d;

  logic pop, advance;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ymrx_pkg::RegBaseAddr);
  assign prdata = (paddr == ymrx_pkg::RegBaseAddr) ? base_q : 32'd0;

  assign m_axis_tvalid = (rem_q != 2'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign advance       = in_valid_q && ((rem_q == 2'd0) || ((rem_q == 2'd1) && pop));
  assign s_axis_tready = !in_valid_q || advance;

  assign m_axis_tuser = res_q[0].kind;
  assign m_axis_tlast = res_q[0].last;
  assign m_axis_tdata = {7'd0, res_q[0].session_ok, res_q[0].erase_length,
                         res_q[0].value, res_q[0].address};

  logic                    first;
  ymrx_pkg::packet_type_e  pt_cur;
  logic                    past_hdr;
  logic [35:0]             acc_x10;
  logic [7:0]              digit;
  logic [IdxW-1:0]         d;
  logic [31:0]             blk;
  logic [31:0]             remaining;
  logic                    is_data_pkt;
  logic                    wr_en;
  ymrx_pkg::res_t          r_write, r_erase, r_ack, r_nak, r_c, r_end;

  always_comb begin
    first    = (idx_q == '0);
    past_hdr = (idx_q >= IdxW'(ymrx_pkg::HeaderBytes));
    if (first) begin
      unique case (byte_q)
        ymrx_pkg::ByteSoh: pt_cur = ymrx_pkg::PT_SOH;
        ymrx_pkg::ByteStx: pt_cur = ymrx_pkg::PT_STX;
        ymrx_pkg::ByteEot: pt_cur = ymrx_pkg::PT_EOT;
        default:           pt_cur = ymrx_pkg::PT_OTHER;
      endcase
    end else begin
      pt_cur = pt_q;
    end
    pt_d  = pt_cur;
    hp_d  = first ? ymrx_pkg::HP_NAME : hp_q;
    acc_d = first ? 32'd0 : acc_q;

    digit = ((byte_q >= ymrx_pkg::CharZero) && (byte_q <= ymrx_pkg::CharNine))
            ? (byte_q - ymrx_pkg::CharZero) : 8'd0;
    acc_x10 = {1'b0, acc_d, 3'b000} + {3'b000, acc_d, 1'b0} + {28'd0, digit};

    if ((ps_q == ymrx_pkg::PS_HEADER) && past_hdr) begin
      unique case (hp_d)
        ymrx_pkg::HP_NAME: begin
          if (byte_q == 8'd0) begin
            hp_d = ymrx_pkg::HP_SIZE;
          end
        end
        ymrx_pkg::HP_SIZE: begin
          if (byte_q == ymrx_pkg::CharSpace) begin
            hp_d = ymrx_pkg::HP_DONE;
          end else begin
            acc_d = (acc_x10[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_x10[31:0];
          end
        end
        default: begin
        end
      endcase
    end

    is_data_pkt = (pt_cur == ymrx_pkg::PT_SOH) || (pt_cur == ymrx_pkg::PT_STX);
    blk         = (pt_cur == ymrx_pkg::PT_SOH) ? 32'(ymrx_pkg::ShortBlock)
                                               : 32'(ymrx_pkg::LongBlock);
    d           = idx_q - IdxW'(ymrx_pkg::HeaderBytes);
    remaining   = fsize_q - offset_q;
    wr_en       = (ps_q == ymrx_pkg::PS_DATA) && past_hdr && is_data_pkt &&
                  ({21'd0, d} < blk) && ({21'd0, d} < remaining);

    r_write              = '0;
    r_write.kind         = ymrx_pkg::KIND_WRITE;
    r_write.address      = base_q + offset_q + {21'd0, d};
    r_write.value        = byte_q;
    r_erase              = '0;
    r_erase.kind         = ymrx_pkg::KIND_ERASE;
    r_erase.address      = base_q;
    r_erase.erase_length = acc_d;
    r_ack                = '0;
    r_ack.kind           = ymrx_pkg::KIND_REPLY;
    r_ack.value          = ymrx_pkg::ReplyAck;
    r_nak                = r_ack;
    r_nak.value          = ymrx_pkg::ReplyNak;
    r_c                  = r_ack;
    r_c.value            = ymrx_pkg::ReplyC;
    r_end                = '0;
    r_end.kind           = ymrx_pkg::KIND_END;

    ps_d     = ps_q;
    fsize_d  = fsize_q;
    offset_d = offset_q;
    res_d[0] = wr_en ? r_write : '0;
    res_d[1] = '0;
    res_d[2] = '0;
    n_d      = wr_en ? 2'd1 : 2'd0;

    if (end_q) begin
      idx_d = '0;
      unique case (ps_q)
        ymrx_pkg::PS_HEADER: begin
          if (pt_cur == ymrx_pkg::PT_SOH) begin
            fsize_d  = acc_d;
            offset_d = 32'd0;
            res_d[0] = r_erase;
            res_d[1] = r_ack;
            res_d[2] = r_c;
            n_d      = 2'd3;
            ps_d     = ymrx_pkg::PS_DATA;
          end else begin
            res_d[0] = r_end;
            n_d      = 2'd1;
          end
        end
        ymrx_pkg::PS_DATA: begin
          if (is_data_pkt) begin
            offset_d = (remaining < blk) ? fsize_q : (offset_q + blk);
            if (wr_en) begin
              res_d[1] = r_ack;
              n_d      = 2'd2;
            end else begin
              res_d[0] = r_ack;
              n_d      = 2'd1;
            end
          end else if (pt_cur == ymrx_pkg::PT_EOT) begin
            res_d[0] = r_nak;
            n_d      = 2'd1;
            ps_d     = ymrx_pkg::PS_EOT2;
          end else begin
            ps_d = ymrx_pkg::PS_HEADER;
          end
        end
        ymrx_pkg::PS_EOT2: begin
          if (pt_cur == ymrx_pkg::PT_EOT) begin
            res_d[0] = r_ack;
            res_d[1] = r_c;
            n_d      = 2'd2;
            ps_d     = ymrx_pkg::PS_CLOSE;
          end
        end
        default: begin
          if (pt_cur == ymrx_pkg::PT_SOH) begin
            res_d[0]            = r_ack;
            res_d[1]            = r_end;
            res_d[1].session_ok = 1'b1;
            n_d                 = 2'd2;
            ps_d                = ymrx_pkg::PS_HEADER;
          end
        end
      endcase
    end else begin
      idx_d = (idx_q == ymrx_pkg::IdxMax) ? idx_q : (idx_q + IdxW'(1));
    end

    res_d[0].last = (n_d == 2'd1);
    res_d[1].last = (n_d == 2'd2);
    res_d[2].last = (n_d == 2'd3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= 32'd0;
      in_valid_q <= 1'b0;
      rem_q      <= 2'd0;
      ps_q       <= ymrx_pkg::PS_HEADER;
      pt_q       <= ymrx_pkg::PT_OTHER;
      hp_q       <= ymrx_pkg::HP_NAME;
      idx_q      <= '0;
      acc_q      <= 32'd0;
      fsize_q    <= 32'd0;
      offset_q   <= 32'd0;
    end else begin
      if (cfg_wr) begin
        base_q <= pwdata;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        rem_q    <= n_d;
        ps_q     <= ps_d;
        pt_q     <= pt_d;
        hp_q     <= hp_d;
        idx_q    <= idx_d;
        acc_q    <= acc_d;
        fsize_q  <= fsize_d;
        offset_q <= offset_d;
      end else if (pop) begin
        rem_q <= rem_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      byte_q <= s_axis_tdata;
      end_q  <= s_axis_tlast;
    end
    if (advance) begin
      res_q[0] <= res_d[0];
      res_q[1] <= res_d[1];
      res_q[2] <= res_d[2];
    end else if (pop) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

endmodule

// ===== rtl/core/ymrx_checker.sv =====
// Port-level checker for the YMODEM receive controller, with its bind.
// Depends on ymrx_pkg and the ports of ymodem_receive_controller.
module ymrx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [ymrx_pkg::TdataOutW-1:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("Output transfer changed while stalled.");

  a_erase_then_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ymrx_pkg::KIND_ERASE) |-> !m_axis_tlast)
    else $error("Erase request must be followed by replies.");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ymrx_pkg::KIND_END) |-> m_axis_tlast)
    else $error("Session end must be the last result of its byte.");

  a_reply_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ymrx_pkg::KIND_REPLY) |->
      (m_axis_tdata[31:0] == 32'd0) && (m_axis_tdata[72:40] == 33'd0) &&
      ((m_axis_tdata[39:32] == ymrx_pkg::ReplyAck) ||
       (m_axis_tdata[39:32] == ymrx_pkg::ReplyNak) ||
       (m_axis_tdata[39:32] == ymrx_pkg::ReplyC)))
    else $error("Malformed reply transfer.");

endmodule

bind ymodem_receive_controller ymrx_checker u_ymrx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
